[rtl/core/tun_pkg.sv]
// Shared widths and transfer types for the triangle unit normal pipeline.
// No dependencies; every other file in rtl/core imports this package.
package tun_pkg;

    localparam int CoordBits = 24;
    localparam int FracBits  = 15;
    localparam int NormBits  = FracBits + 1;
    localparam int EdgeBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * EdgeBits;
    localparam int DiffBits  = ProdBits + 1;
    localparam int CrossMag  = 2 * CoordBits + 1;
    localparam int LoBits    = CoordBits + 1;
    localparam int HiBits    = CrossMag - LoBits;
    localparam int SqBits    = 2 * CrossMag;
    localparam int SumBits   = SqBits + 2;
    localparam int RootSteps = FracBits + 2;
    localparam int MBits     = FracBits + 2;
    localparam int WideBits  = SumBits + 2 * FracBits + 5;

    typedef struct packed {
        logic signed [CoordBits-1:0] first_x;
        logic signed [CoordBits-1:0] first_y;
        logic signed [CoordBits-1:0] first_z;
        logic signed [CoordBits-1:0] second_x;
        logic signed [CoordBits-1:0] second_y;
        logic signed [CoordBits-1:0] second_z;
        logic signed [CoordBits-1:0] third_x;
        logic signed [CoordBits-1:0] third_y;
        logic signed [CoordBits-1:0] third_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [NormBits-1:0] normal_x;
        logic signed [NormBits-1:0] normal_y;
        logic signed [NormBits-1:0] normal_z;
        logic                       degenerate;
    } t_tri_out;

    typedef struct packed {
        logic [2:0][CrossMag-1:0] mag;
        logic [2:0]               neg;
    } t_cross;

    typedef struct packed {
        logic [SumBits-1:0]     sum;
        logic [2:0][SqBits-1:0] sq;
        logic [2:0]             neg;
        logic                   degen;
    } t_sq;

    typedef struct packed {
        logic [SumBits-1:0]       sum;
        logic [2:0][WideBits-1:0] rem;
        logic [2:0][WideBits-1:0] prod;
        logic [2:0][MBits-1:0]    m;
        logic [2:0]               neg;
        logic                     degen;
    } t_root;

endpackage

[rtl/core/triangle_unit_normal_unit.sv]
// Top level of the triangle unit normal pipeline: cross, square sum, root, output stage.
// Depends on tun_pkg, tun_cross, tun_sqsum and tun_root.
//
//   channel   direction   handshake            payload
//   input     in          i_valid / o_stall    i_data (t_tri_in)
//   output    out         o_valid / i_stall    o_data (t_tri_out)
//
// One triangle per cycle sustained while i_stall is low; stages are 3 cross, 3 square sum,
// 17 root bit stages and 1 output register.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse under i_stall and a held result blocks intake only when no stage is empty.
module triangle_unit_normal_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tun_pkg::t_tri_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output tun_pkg::t_tri_out o_data
);
    import tun_pkg::*;

    localparam logic [MBits-1:0] Full = MBits'(1) << FracBits;

    logic                       x_valid;
    logic                       x_stall;
    t_cross                     x_data;
    logic                       s_valid;
    logic                       s_stall;
    t_sq                        s_data;
    logic                       root_v;
    logic                       root_stall;
    t_root                      root_d;
    logic                       en_out;
    logic [MBits-1:0]           q;
    logic signed [NormBits-1:0] comp [3];
    t_tri_out                   n_out;
    t_tri_out                   r_out;
    logic                       r_out_v;

    tun_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (x_valid),
        .i_stall (x_stall),
        .o_data  (x_data)
    );

    tun_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (x_valid),
        .o_stall (x_stall),
        .i_data  (x_data),
        .o_valid (s_valid),
        .i_stall (s_stall),
        .o_data  (s_data)
    );

    tun_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .o_stall (s_stall),
        .i_data  (s_data),
        .o_valid (root_v),
        .i_stall (root_stall),
        .o_data  (root_d)
    );

    assign en_out     = !r_out_v || !i_stall;
    assign root_stall = !en_out;

    // round half away, clamp magnitude to 1.0; +1.0 saturates to the largest positive code
    always_comb begin
        q = '0;
        for (int i = 0; i < 3; i++) begin
            q = (root_d.m[i] + MBits'(1)) >> 1;
            if (q > Full) q = Full;
            if (root_d.neg[i]) begin
                comp[i] = NormBits'(MBits'(0) - q);
            end else if (q == Full) begin
                comp[i] = NormBits'(Full - MBits'(1));
            end else begin
                comp[i] = NormBits'(q);
            end
            if (root_d.degen) comp[i] = '0;
        end
        n_out.normal_x   = comp[0];
        n_out.normal_y   = comp[1];
        n_out.normal_z   = comp[2];
        n_out.degenerate = root_d.degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= root_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) r_out <= n_out;
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

[rtl/core/tun_cross.sv]
// Edge vectors, partial products and cross product magnitudes, three stages.
// Depends on tun_pkg.
module tun_cross (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  tun_pkg::t_tri_in i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output tun_pkg::t_cross  o_data
);
    import tun_pkg::*;

    localparam int Stages = 3;

    logic [Stages-1:0]          r_vld;
    logic [Stages-1:0]          en;
    logic signed [EdgeBits-1:0] r_ea [3];
    logic signed [EdgeBits-1:0] r_eb [3];
    logic signed [ProdBits-1:0] r_p [6];
    logic signed [DiffBits-1:0] d [3];
    t_cross                     r_x;

    always_comb begin
        en[Stages-1] = !r_vld[Stages-1] || !i_stall;
        for (int k = Stages - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < Stages; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        d[0] = DiffBits'(r_p[0]) - DiffBits'(r_p[1]);
        d[1] = DiffBits'(r_p[2]) - DiffBits'(r_p[3]);
        d[2] = DiffBits'(r_p[4]) - DiffBits'(r_p[5]);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ea[0] <= EdgeBits'(i_data.second_x) - EdgeBits'(i_data.first_x);
            r_ea[1] <= EdgeBits'(i_data.second_y) - EdgeBits'(i_data.first_y);
            r_ea[2] <= EdgeBits'(i_data.second_z) - EdgeBits'(i_data.first_z);
            r_eb[0] <= EdgeBits'(i_data.third_x) - EdgeBits'(i_data.first_x);
            r_eb[1] <= EdgeBits'(i_data.third_y) - EdgeBits'(i_data.first_y);
            r_eb[2] <= EdgeBits'(i_data.third_z) - EdgeBits'(i_data.first_z);
        end
        if (en[1]) begin
            r_p[0] <= r_ea[1] * r_eb[2];
            r_p[1] <= r_ea[2] * r_eb[1];
            r_p[2] <= r_ea[2] * r_eb[0];
            r_p[3] <= r_ea[0] * r_eb[2];
            r_p[4] <= r_ea[0] * r_eb[1];
            r_p[5] <= r_ea[1] * r_eb[0];
        end
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_x.neg[i] <= d[i][DiffBits-1];
                r_x.mag[i] <= d[i][DiffBits-1] ? CrossMag'(-d[i]) : CrossMag'(d[i]);
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[Stages-1];
    assign o_data  = r_x;

endmodule

[rtl/core/tun_sqsum.sv]
// Squares of the cross components from split products and their sum, three stages.
// Depends on tun_pkg.
module tun_sqsum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  tun_pkg::t_cross i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output tun_pkg::t_sq    o_data
);
    import tun_pkg::*;

    localparam int Stages = 3;

    logic [Stages-1:0]                r_vld;
    logic [Stages-1:0]                en;
    logic [HiBits-1:0]                hi [3];
    logic [LoBits-1:0]                lo [3];
    logic [2:0][2*HiBits-1:0]         r_hh;
    logic [2:0][HiBits+LoBits-1:0]    r_hl;
    logic [2:0][2*LoBits-1:0]         r_ll;
    logic [2:0][SqBits-1:0]           r_sq;
    logic [2:0]                       r_neg1;
    logic [2:0]                       r_neg2;
    logic                             r_deg1;
    logic                             r_deg2;
    t_sq                              r_s;

    always_comb begin
        en[Stages-1] = !r_vld[Stages-1] || !i_stall;
        for (int k = Stages - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        for (int i = 0; i < 3; i++) begin
            hi[i] = i_data.mag[i][CrossMag-1:LoBits];
            lo[i] = i_data.mag[i][LoBits-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < Stages; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_hh[i] <= hi[i] * hi[i];
                r_hl[i] <= hi[i] * lo[i];
                r_ll[i] <= lo[i] * lo[i];
            end
            r_neg1 <= i_data.neg;
            r_deg1 <= (i_data.mag == '0);
        end
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (SqBits'(r_hh[i]) << (2 * LoBits))
                         + (SqBits'(r_hl[i]) << (LoBits + 1))
                         + SqBits'(r_ll[i]);
            end
            r_neg2 <= r_neg1;
            r_deg2 <= r_deg1;
        end
        if (en[2]) begin
            r_s.sum   <= SumBits'(r_sq[0]) + SumBits'(r_sq[1]) + SumBits'(r_sq[2]);
            r_s.sq    <= r_sq;
            r_s.neg   <= r_neg2;
            r_s.degen <= r_deg2;
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[Stages-1];
    assign o_data  = r_s;

endmodule

[rtl/core/tun_root.sv]
// Restoring digit recurrence for floor(2*|c|*2^F/sqrt(S)), one bit per stage.
// Depends on tun_pkg.
module tun_root (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  tun_pkg::t_sq   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output tun_pkg::t_root o_data
);
    import tun_pkg::*;

    logic [RootSteps-1:0] r_vld;
    logic [RootSteps-1:0] en;
    t_root                init;
    t_root                r_st [RootSteps];

    // rem = c^2*2^(2F+2) - m^2*S, prod = m*S
    function automatic t_root step(input t_root s, input int b);
        t_root               o;
        logic [WideBits-1:0] trial;
        o = s;
        for (int i = 0; i < 3; i++) begin
            trial = (s.prod[i] << (b + 1)) + (WideBits'(s.sum) << (2 * b));
            if (s.rem[i] >= trial) begin
                o.rem[i]  = s.rem[i] - trial;
                o.prod[i] = s.prod[i] + (WideBits'(s.sum) << b);
                o.m[i]    = s.m[i] | (MBits'(1) << b);
            end
        end
        return o;
    endfunction

    always_comb begin
        en[RootSteps-1] = !r_vld[RootSteps-1] || !i_stall;
        for (int k = RootSteps - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        init       = '0;
        init.sum   = i_data.sum;
        init.neg   = i_data.neg;
        init.degen = i_data.degen;
        for (int i = 0; i < 3; i++) begin
            init.rem[i] = WideBits'(i_data.sq[i]) << (2 * FracBits + 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < RootSteps; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) r_st[0] <= step(init, RootSteps - 1);
        for (int k = 1; k < RootSteps; k++) begin
            if (en[k]) r_st[k] <= step(r_st[k-1], RootSteps - 1 - k);
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[RootSteps-1];
    assign o_data  = r_st[RootSteps-1];

endmodule

[rtl/core/tun_checker.sv]
// Port-level checks for triangle_unit_normal_unit and the bind that attaches them.
// Depends on tun_pkg and the top level's ports.
module tun_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input tun_pkg::t_tri_out o_data
);
    import tun_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output transfer dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("output payload changed under stall");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |->
            o_data.normal_x == '0 && o_data.normal_y == '0 && o_data.normal_z == '0)
        else $error("degenerate result with nonzero normal");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

bind triangle_unit_normal_unit tun_checker u_chk (.*);
